### hw/rtl/cau_pkg.sv
package cau_pkg;

    // Default operand format: signed Q4.12
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;

    // Operation codes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Per-request flags carried down the pipeline
    typedef struct packed {
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
        logic dz;
        logic is_div;
    } cau_flags_t;

endpackage

### hw/rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// operands in signed fixed point (Q4.12 by default).
// Input channel: in_valid / in_stall with operation, a_re, a_im, b_re, b_im.
// Output channel: out_valid / out_stall with res_re, res_im, overflow and
// div_by_zero. A request is taken on a rising edge with valid high and
// stall low.
// The pipeline has three set-up stages (products, sums, divider set-up),
// DATA_WIDTH + 1 divider cells giving one quotient bit each, and the
// saturating output register. Throughput is one request per cycle on every
// operation while in_stall is low.
// When the receiver stalls, requests keep moving into empty stages behind
// the held result; in_stall rises only once the pipeline is full.
// Reset clears all valid bits; the pipeline starts empty and out_valid low.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   operation,
    input  logic signed [DATA_WIDTH-1:0] a_re,
    input  logic signed [DATA_WIDTH-1:0] a_im,
    input  logic signed [DATA_WIDTH-1:0] b_re,
    input  logic signed [DATA_WIDTH-1:0] b_im,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output logic                         overflow,
    output logic                         div_by_zero
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = 3*W + FRAC_BITS + 2;
    localparam int QW = 2*W + 1;
    localparam int NC = W + 1;
    localparam int NS = NC + 4;
    localparam logic [QW-1:0] HALF = QW'(1) << (W - 1);

    // Stage valids and load enables
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];

    // Data chain: set-up stages then divider cells
    logic [CW-1:0] rem_re_c [NC+1];
    logic [CW-1:0] rem_im_c [NC+1];
    logic [CW-1:0] den_c    [NC+1];
    logic [QW-1:0] q_re_c   [NC+1];
    logic [QW-1:0] q_im_c   [NC+1];
    cau_flags_t    flags_c  [NC+1];

    cau_prep #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_prep (
        .clk       (clk),
        .en        (en[2:0]),
        .operation (operation),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .rem_re    (rem_re_c[0]),
        .rem_im    (rem_im_c[0]),
        .den       (den_c[0]),
        .q_re      (q_re_c[0]),
        .q_im      (q_im_c[0]),
        .flags     (flags_c[0])
    );

    // Cell j resolves quotient bit W - j, most significant first
    for (genvar j = 0; j < NC; j++)
    begin : g_cell
        cau_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .BIT        (W - j)
        ) u_cell (
            .clk       (clk),
            .en        (en[3+j]),
            .rem_re_in (rem_re_c[j]),
            .rem_im_in (rem_im_c[j]),
            .den_in    (den_c[j]),
            .q_re_in   (q_re_c[j]),
            .q_im_in   (q_im_c[j]),
            .flags_in  (flags_c[j]),
            .rem_re    (rem_re_c[j+1]),
            .rem_im    (rem_im_c[j+1]),
            .den       (den_c[j+1]),
            .q_re      (q_re_c[j+1]),
            .q_im      (q_im_c[j+1]),
            .flags     (flags_c[j+1])
        );
    end

    // Output stage: saturate and apply sign, or clear on divide by zero
    cau_flags_t    fl;
    logic [QW-1:0] lim_re, lim_im, m_re, m_im;
    logic          sat_re, sat_im;
    logic [W-1:0]  res_re_next, res_im_next;

    always_comb
    begin
        fl     = flags_c[NC];
        lim_re = fl.neg_re ? HALF : HALF - 1'b1;
        lim_im = fl.neg_im ? HALF : HALF - 1'b1;
        sat_re = fl.big_re || (q_re_c[NC] > lim_re);
        sat_im = fl.big_im || (q_im_c[NC] > lim_im);
        m_re   = sat_re ? lim_re : q_re_c[NC];
        m_im   = sat_im ? lim_im : q_im_c[NC];
        res_re_next = fl.neg_re ? W'(~m_re + 1'b1) : m_re[W-1:0];
        res_im_next = fl.neg_im ? W'(~m_im + 1'b1) : m_im[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            if (fl.dz)
            begin
                res_re   <= '0;
                res_im   <= '0;
                overflow <= 1'b0;
            end
            else
            begin
                res_re   <= res_re_next;
                res_im   <= res_im_next;
                overflow <= sat_re || sat_im;
            end
            div_by_zero <= fl.dz;
        end
    end

`ifndef SYNTHESIS
    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && div_by_zero |-> res_re == '0 && res_im == '0 && !overflow)
        else $error("divide by zero result not cleared");

    a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> res_re == SMAX || res_re == SMIN ||
                                  res_im == SMAX || res_im == SMIN)
        else $error("overflow flagged without a saturated part");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[NS-1] |-> !in_stall)
        else $error("input stalled with an empty output stage");
`endif

endmodule

### hw/rtl/cau_prep.sv
module cau_prep #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                     clk,
    input  logic [2:0]                               en,
    input  logic [1:0]                               operation,
    input  logic signed [DATA_WIDTH-1:0]             a_re,
    input  logic signed [DATA_WIDTH-1:0]             a_im,
    input  logic signed [DATA_WIDTH-1:0]             b_re,
    input  logic signed [DATA_WIDTH-1:0]             b_im,
    output logic [3*DATA_WIDTH+FRAC_BITS+1:0]        rem_re,
    output logic [3*DATA_WIDTH+FRAC_BITS+1:0]        rem_im,
    output logic [3*DATA_WIDTH+FRAC_BITS+1:0]        den,
    output logic [2*DATA_WIDTH:0]                    q_re,
    output logic [2*DATA_WIDTH:0]                    q_im,
    output cau_pkg::cau_flags_t                      flags
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int MW = 2*W + 1;
    localparam int CW = MW + F + W + 1;

    // Stage 1: all products
    logic [1:0]              op1_reg;
    logic signed [W-1:0]     ar1_reg, ai1_reg, br1_reg, bi1_reg;
    logic signed [2*W-1:0]   p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            op1_reg  <= operation;
            ar1_reg  <= a_re;
            ai1_reg  <= a_im;
            br1_reg  <= b_re;
            bi1_reg  <= b_im;
            p_rr_reg <= a_re * b_re;
            p_ii_reg <= a_im * b_im;
            p_ri_reg <= a_re * b_im;
            p_ir_reg <= a_im * b_re;
            sq_r_reg <= b_re * b_re;
            sq_i_reg <= b_im * b_im;
        end
    end

    // Stage 2: exact sums, split into sign and magnitude
    logic signed [MW-1:0] s_re, s_im;
    logic [MW-1:0]        den_next, mag_re_next, mag_im_next;
    logic [1:0]           op2_reg;
    logic [MW-1:0]        den2_reg, mag_re_reg, mag_im_reg;
    logic                 neg_re_reg, neg_im_reg;

    always_comb
    begin
        den_next = {1'b0, sq_r_reg} + {1'b0, sq_i_reg};
        case (op1_reg)
            OP_ADD:
            begin
                s_re = MW'(ar1_reg) + MW'(br1_reg);
                s_im = MW'(ai1_reg) + MW'(bi1_reg);
            end
            OP_SUB:
            begin
                s_re = MW'(ar1_reg) - MW'(br1_reg);
                s_im = MW'(ai1_reg) - MW'(bi1_reg);
            end
            OP_MUL:
            begin
                s_re = MW'(p_rr_reg) - MW'(p_ii_reg);
                s_im = MW'(p_ri_reg) + MW'(p_ir_reg);
            end
            default:
            begin
                s_re = MW'(p_rr_reg) + MW'(p_ii_reg);
                s_im = MW'(p_ir_reg) - MW'(p_ri_reg);
            end
        endcase
        mag_re_next = s_re[MW-1] ? (~s_re + 1'b1) : s_re;
        mag_im_next = s_im[MW-1] ? (~s_im + 1'b1) : s_im;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            op2_reg    <= op1_reg;
            den2_reg   <= den_next;
            mag_re_reg <= mag_re_next;
            mag_im_reg <= mag_im_next;
            neg_re_reg <= s_re[MW-1];
            neg_im_reg <= s_im[MW-1];
        end
    end

    // Stage 3: set up the divider, or the final magnitude for other ops
    logic [CW-1:0] num_re_sh, num_im_sh, den_top;
    logic          is_div;

    always_comb
    begin
        is_div    = (op2_reg == OP_DIV);
        num_re_sh = CW'(mag_re_reg) << F;
        num_im_sh = CW'(mag_im_reg) << F;
        den_top   = CW'(den2_reg) << (W + 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            rem_re       <= num_re_sh;
            rem_im       <= num_im_sh;
            den          <= CW'(den2_reg);
            flags.neg_re <= neg_re_reg;
            flags.neg_im <= neg_im_reg;
            flags.is_div <= is_div;
            flags.dz     <= is_div && (den2_reg == '0);
            flags.big_re <= is_div && (num_re_sh >= den_top);
            flags.big_im <= is_div && (num_im_sh >= den_top);
            case (op2_reg)
                OP_MUL:
                begin
                    q_re <= mag_re_reg >> F;
                    q_im <= mag_im_reg >> F;
                end
                OP_DIV:
                begin
                    q_re <= '0;
                    q_im <= '0;
                end
                default:
                begin
                    q_re <= mag_re_reg;
                    q_im <= mag_im_reg;
                end
            endcase
        end
    end

endmodule

### hw/rtl/cau_cell.sv
module cau_cell #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12,
    parameter int BIT        = 0
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [3*DATA_WIDTH+FRAC_BITS+1:0] rem_re_in,
    input  logic [3*DATA_WIDTH+FRAC_BITS+1:0] rem_im_in,
    input  logic [3*DATA_WIDTH+FRAC_BITS+1:0] den_in,
    input  logic [2*DATA_WIDTH:0]             q_re_in,
    input  logic [2*DATA_WIDTH:0]             q_im_in,
    input  cau_pkg::cau_flags_t               flags_in,
    output logic [3*DATA_WIDTH+FRAC_BITS+1:0] rem_re,
    output logic [3*DATA_WIDTH+FRAC_BITS+1:0] rem_im,
    output logic [3*DATA_WIDTH+FRAC_BITS+1:0] den,
    output logic [2*DATA_WIDTH:0]             q_re,
    output logic [2*DATA_WIDTH:0]             q_im,
    output cau_pkg::cau_flags_t               flags
);
    import cau_pkg::*;

    localparam int CW = 3*DATA_WIDTH + FRAC_BITS + 2;

    // One restoring step per lane: quotient bit BIT
    logic [CW-1:0]         dsh;
    logic                  take_re, take_im;
    logic [2*DATA_WIDTH:0] q_re_next, q_im_next;

    always_comb
    begin
        dsh     = den_in << BIT;
        take_re = flags_in.is_div && (rem_re_in >= dsh);
        take_im = flags_in.is_div && (rem_im_in >= dsh);
        q_re_next      = q_re_in;
        q_im_next      = q_im_in;
        q_re_next[BIT] = q_re_in[BIT] | take_re;
        q_im_next[BIT] = q_im_in[BIT] | take_im;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_re <= take_re ? rem_re_in - dsh : rem_re_in;
            rem_im <= take_im ? rem_im_in - dsh : rem_im_in;
            den    <= den_in;
            flags  <= flags_in;
            q_re   <= q_re_next;
            q_im   <= q_im_next;
        end
    end

endmodule
